/* hw/rtl/assert_macros.svh */
// Assertion macros included by the allocator top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* hw/rtl/lsra_pkg.sv */
// Shared constants, codes and control types of the register allocator.
package lsra_pkg;

  localparam int POOL_SIZE     = 12;
  localparam int POSITION_BITS = 16;
  localparam int ID_BITS       = 16;

  localparam int FIELD_W   = 16;  // width of id/start/end input fields
  localparam int OUTCOME_W = 2;
  localparam int INDEX_W   = 4;
  localparam int PHYS_W    = 5;
  localparam int EVICT_W   = 16;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FREE  = 2'd0,
    OUT_SPILL = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic load;    // take input beat, clear/expire slots
    logic search;  // register free pick and first victim stage
    logic commit;  // final victim pick, slot write, result out
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } sts_t;

endpackage

/* hw/rtl/linear_scan_register_allocator.sv */
// Linear-scan register allocator. Intervals arrive one beat at a time in order of
// increasing start; each beat yields exactly one result beat telling whether the
// interval got a free register, evicted an active interval, or was spilled. In the
// accepting cycle the block expires/clears the slots; the search step then does the
// free-slot pick and the first level of the largest-end search (groups of four slots),
// and the commit step does the final victim pick, the slot write and the result write.
// The next beat is accepted only after the result is written, so the block does not
// take a new beat while one is in work; a stalled master side holds the block in its
// commit step until the result is taken.
`include "assert_macros.svh"

module linear_scan_register_allocator #(
  parameter int POOL_SIZE     = lsra_pkg::POOL_SIZE,
  parameter int POSITION_BITS = lsra_pkg::POSITION_BITS,
  parameter int ID_BITS       = lsra_pkg::ID_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // ival_id[15:0], start_point[31:16], end_point[47:32]
  input  logic [1:0]  s_tuser,   // new_function[0], float_class[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // register_index[3:0], physical_register[8:4],
                                 // evicted_id[24:9], zero[31:25]
  output logic [1:0]  m_tuser    // outcome[1:0]
);

  lsra_pkg::cmd_t     cmd;
  lsra_pkg::sts_t     sts;
  lsra_pkg::outcome_t outcome;
  logic [lsra_pkg::INDEX_W-1:0] register_index;
  logic [lsra_pkg::PHYS_W-1:0]  physical_register;
  logic [lsra_pkg::EVICT_W-1:0] evicted_id;

  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsra_dp #(
    .POOL_SIZE     (POOL_SIZE),
    .POSITION_BITS (POSITION_BITS),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .new_function      (s_tuser[0]),
    .ival_id           (s_tdata[15:0]),
    .start_point       (s_tdata[31:16]),
    .end_point         (s_tdata[47:32]),
    .float_class       (s_tuser[1]),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .outcome           (outcome),
    .register_index    (register_index),
    .physical_register (physical_register),
    .evicted_id        (evicted_id)
  );

  assign m_tdata = {7'd0, evicted_id, physical_register, register_index};
  assign m_tuser = outcome;

  // a spilled interval carries no register and no eviction
  `ASSERT_IMPLIES(a_spill_empty, clk, rst,
    m_tvalid && (outcome == lsra_pkg::OUT_SPILL),
    (register_index == '0) && (physical_register == '0) && (evicted_id == '0))
  `ASSERT_IMPLIES(a_evict_id_zero, clk, rst,
    m_tvalid && (outcome != lsra_pkg::OUT_EVICT), evicted_id == '0)
  // no new beat while one is being worked on
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPLIES(a_commit_slot_free, clk, rst, cmd.commit, !sts.out_busy)

endmodule

/* hw/rtl/lsra_ctrl.sv */
// Sequencer of the register allocator: accept, search, commit.
module lsra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lsra_pkg::sts_t sts,
  output lsra_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.search = (state == S_SEARCH);
  assign cmd.commit = (state == S_COMMIT) && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SEARCH;
        end
        S_SEARCH: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/lsra_dp.sv */
// Slot file, free/victim search and result register of the allocator.
module lsra_dp #(
  parameter int POOL_SIZE     = lsra_pkg::POOL_SIZE,
  parameter int POSITION_BITS = lsra_pkg::POSITION_BITS,
  parameter int ID_BITS       = lsra_pkg::ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lsra_pkg::cmd_t                    cmd,
  output lsra_pkg::sts_t                    sts,
  input  logic                              new_function,
  input  logic [lsra_pkg::FIELD_W-1:0]      ival_id,
  input  logic [lsra_pkg::FIELD_W-1:0]      start_point,
  input  logic [lsra_pkg::FIELD_W-1:0]      end_point,
  input  logic                              float_class,
  input  logic                              out_ready,
  output logic                              out_valid,
  output lsra_pkg::outcome_t                outcome,
  output logic [lsra_pkg::INDEX_W-1:0]      register_index,
  output logic [lsra_pkg::PHYS_W-1:0]       physical_register,
  output logic [lsra_pkg::EVICT_W-1:0]      evicted_id
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int GRP   = 4;
  localparam int NG    = (POOL_SIZE + GRP - 1) / GRP;
  localparam int PAD   = NG * GRP;
  localparam int SUM_W = IDX_W + 6;

  // slot file, [class][slot]; class 1 is float
  logic                     slot_valid [2][POOL_SIZE];
  logic [ID_BITS-1:0]       slot_id    [2][POOL_SIZE];
  logic [POSITION_BITS-1:0] slot_end   [2][POOL_SIZE];

  logic [ID_BITS-1:0]       cur_id;
  logic [POSITION_BITS-1:0] cur_end;
  logic                     cur_float;
  logic [POSITION_BITS-1:0] start_in;

  assign start_in = POSITION_BITS'(start_point);

  function automatic logic better(
    input logic                     a_ok,
    input logic [POSITION_BITS-1:0] a_end,
    input logic [ID_BITS-1:0]       a_id,
    input logic                     b_ok,
    input logic [POSITION_BITS-1:0] b_end,
    input logic [ID_BITS-1:0]       b_id
  );
    better = a_ok && (!b_ok || (a_end > b_end) || ((a_end == b_end) && (a_id < b_id)));
  endfunction

  // ---------------- search stage ----------------
  logic [POOL_SIZE-1:0]     free_vec;
  logic                     free_any;
  logic [IDX_W-1:0]         free_idx;
  logic                     cand_ok  [PAD];
  logic [POSITION_BITS-1:0] cand_end [PAD];
  logic [ID_BITS-1:0]       cand_id  [PAD];

  genvar gk, gg;
  for (gk = 0; gk < PAD; gk++) begin : g_cand
    if (gk < POOL_SIZE) begin : g_real
      // slot 0 is not in the integer pool
      assign cand_ok[gk]  = slot_valid[cur_float][gk] && (cur_float || (gk != 0));
      assign cand_end[gk] = slot_end[cur_float][gk];
      assign cand_id[gk]  = slot_id[cur_float][gk];
      assign free_vec[gk] = !slot_valid[cur_float][gk] && (cur_float || (gk != 0));
    end else begin : g_pad
      assign cand_ok[gk]  = 1'b0;
      assign cand_end[gk] = '0;
      assign cand_id[gk]  = '0;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int k = POOL_SIZE - 1; k >= 0; k--) begin
      if (free_vec[k]) free_idx = IDX_W'(k);
    end
  end
  assign free_any = |free_vec;

  logic                     grp_ok_c  [NG];
  logic [POSITION_BITS-1:0] grp_end_c [NG];
  logic [ID_BITS-1:0]       grp_id_c  [NG];
  logic [IDX_W-1:0]         grp_idx_c [NG];

  for (gg = 0; gg < NG; gg++) begin : g_grp
    always_comb begin
      grp_ok_c[gg]  = 1'b0;
      grp_end_c[gg] = '0;
      grp_id_c[gg]  = '0;
      grp_idx_c[gg] = '0;
      // strict compare keeps the lower slot on a full tie
      for (int j = 0; j < GRP; j++) begin
        if (better(cand_ok[gg*GRP+j], cand_end[gg*GRP+j], cand_id[gg*GRP+j],
                   grp_ok_c[gg], grp_end_c[gg], grp_id_c[gg])) begin
          grp_ok_c[gg]  = 1'b1;
          grp_end_c[gg] = cand_end[gg*GRP+j];
          grp_id_c[gg]  = cand_id[gg*GRP+j];
          grp_idx_c[gg] = IDX_W'(gg*GRP+j);
        end
      end
    end
  end

  logic                     grp_ok  [NG];
  logic [POSITION_BITS-1:0] grp_end [NG];
  logic [ID_BITS-1:0]       grp_id  [NG];
  logic [IDX_W-1:0]         grp_idx [NG];
  logic                     free_any_q;
  logic [IDX_W-1:0]         free_idx_q;

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      free_any_q <= free_any;
      free_idx_q <= free_idx;
      for (int g = 0; g < NG; g++) begin
        grp_ok[g]  <= grp_ok_c[g];
        grp_end[g] <= grp_end_c[g];
        grp_id[g]  <= grp_id_c[g];
        grp_idx[g] <= grp_idx_c[g];
      end
    end
  end

  // ---------------- commit stage ----------------
  logic                     vic_ok;
  logic [POSITION_BITS-1:0] vic_end;
  logic [ID_BITS-1:0]       vic_id;
  logic [IDX_W-1:0]         vic_idx;

  always_comb begin
    vic_ok  = 1'b0;
    vic_end = '0;
    vic_id  = '0;
    vic_idx = '0;
    for (int g = 0; g < NG; g++) begin
      if (better(grp_ok[g], grp_end[g], grp_id[g], vic_ok, vic_end, vic_id)) begin
        vic_ok  = 1'b1;
        vic_end = grp_end[g];
        vic_id  = grp_id[g];
        vic_idx = grp_idx[g];
      end
    end
  end

  lsra_pkg::outcome_t   oc;
  logic [IDX_W-1:0]     pick;
  logic                 wr_en;
  logic [ID_BITS-1:0]   ev_id;
  logic [SUM_W-1:0]     phys_sum;

  always_comb begin
    priority if (free_any_q) begin
      oc    = lsra_pkg::OUT_FREE;
      pick  = free_idx_q;
      wr_en = 1'b1;
      ev_id = '0;
    end else if (vic_ok && (vic_end > cur_end)) begin
      oc    = lsra_pkg::OUT_EVICT;
      pick  = vic_idx;
      wr_en = 1'b1;
      ev_id = vic_id;
    end else begin
      oc    = lsra_pkg::OUT_SPILL;
      pick  = '0;
      wr_en = 1'b0;
      ev_id = '0;
    end
    phys_sum = (pick <= IDX_W'(1)) ? (SUM_W'(pick) + SUM_W'(8))
                                   : (SUM_W'(pick) + SUM_W'(16));
  end

  // ---------------- slot file ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < POOL_SIZE; k++) slot_valid[c][k] <= 1'b0;
      end
    end else if (cmd.load) begin
      // function start clears both classes; otherwise expire ended intervals
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < POOL_SIZE; k++) begin
          slot_valid[c][k] <= !new_function && slot_valid[c][k] &&
                              !(slot_end[c][k] < start_in);
        end
      end
    end else if (cmd.commit && wr_en) begin
      slot_valid[cur_float][pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      slot_id[cur_float][pick]  <= cur_id;
      slot_end[cur_float][pick] <= cur_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_id    <= ID_BITS'(ival_id);
      cur_end   <= POSITION_BITS'(end_point);
      cur_float <= float_class;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome           <= oc;
      register_index    <= wr_en ? lsra_pkg::INDEX_W'(pick) : '0;
      physical_register <= wr_en ? phys_sum[lsra_pkg::PHYS_W-1:0] : '0;
      evicted_id        <= lsra_pkg::EVICT_W'(ev_id);
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

/* tb/tb.sv */
// Self-checking bench for the linear-scan register allocator: directed table, then random runs.
module tb;
  import lsra_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PLAN_ROWS = 23;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        nf;
    logic [15:0] id;
    logic [15:0] st;
    logic [15:0] en;
    logic        fl;
  } interval_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [3:0]  idx;
    logic [4:0]  phys;
    logic [15:0] evicted;
  } alloc_result_t;

  typedef struct packed {
    interval_t     iv;
    logic          given;
    alloc_result_t res;
  } plan_row_t;

  typedef struct packed {
    logic        live;
    logic [15:0] id;
    logic [15:0] stop;
  } slot_t;

  localparam alloc_result_t UNTYPED = '{OUT_FREE, 4'd0, 5'd0, 16'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // ival_id, start_point, end_point
  logic [1:0]  s_tuser = '0;  // new_function, float_class
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // register_index, physical_register, evicted_id, zero
  logic [1:0]  m_tuser;       // outcome

  slot_t         slot_file [2][POOL_SIZE];
  alloc_result_t expected_allocs [$];
  int            mismatches = 0;
  int            cycles = 0;
  int            snd_idle = 13;
  int            rcv_idle = 58;
  logic          hold_off = 1'b0;
  logic          squeeze = 1'b0;
  plan_row_t     plan [PLAN_ROWS];

  linear_scan_register_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic alloc_result_t allocate_interval(input interval_t iv);
    alloc_result_t r;
    int cls;
    int first;
    int pick;
    int victim;
    r = UNTYPED;
    cls = iv.fl ? 1 : 0;
    first = iv.fl ? 0 : 1;
    pick = -1;
    victim = -1;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (iv.nf) slot_file[c][k] = '0;
        else if (slot_file[c][k].live && slot_file[c][k].stop < iv.st)
          slot_file[c][k].live = 1'b0;
      end
    end
    for (int k = first; k < POOL_SIZE; k++)
      if (pick < 0 && !slot_file[cls][k].live) pick = k;
    if (pick >= 0) begin
      r.outcome = OUT_FREE;
    end else begin
      // largest end wins, then smaller id, then lowest slot
      for (int k = first; k < POOL_SIZE; k++) begin
        if (victim < 0 || slot_file[cls][k].stop > slot_file[cls][victim].stop ||
            (slot_file[cls][k].stop == slot_file[cls][victim].stop &&
             slot_file[cls][k].id < slot_file[cls][victim].id))
          victim = k;
      end
      if (slot_file[cls][victim].stop > iv.en) begin
        r.outcome = OUT_EVICT;
        r.evicted = slot_file[cls][victim].id;
        pick = victim;
      end else begin
        r.outcome = OUT_SPILL;
      end
    end
    if (pick >= 0) begin
      slot_file[cls][pick] = '{1'b1, iv.id, iv.en};
      r.idx = 4'(pick);
      r.phys = (pick <= 1) ? 5'(pick + 8) : 5'(pick + 16);
    end
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %h, got %h (cycle %0d)", what, want, got, cycles);
  endtask

  task automatic check_beat();
    alloc_result_t want;
    if (expected_allocs.size() == 0) begin
      flag("result beat with nothing pending", 32'd0, m_tdata);
      return;
    end
    want = expected_allocs.pop_front();
    if (m_tuser !== want.outcome) flag("outcome", 32'(want.outcome), 32'(m_tuser));
    if (m_tdata[3:0] !== want.idx) flag("register_index", 32'(want.idx), 32'(m_tdata[3:0]));
    if (m_tdata[8:4] !== want.phys)
      flag("physical_register", 32'(want.phys), 32'(m_tdata[8:4]));
    if (m_tdata[24:9] !== want.evicted)
      flag("evicted_id", 32'(want.evicted), 32'(m_tdata[24:9]));
  endtask

  task automatic offer_interval(input interval_t iv, input logic given,
                                input alloc_result_t typed);
    alloc_result_t want;
    while (chance(snd_idle)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {iv.en, iv.st, iv.id};
    s_tuser <= {iv.fl, iv.nf};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = allocate_interval(iv);
    if (given) want = typed;
    expected_allocs = {expected_allocs, want};
  endtask

  // result side: check taken beats, then pick next ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      m_tready <= hold_off ? 1'b0 : !chance(rcv_idle);
    end
  end

  // long receiver stall so the result register fills and the input backs up
  initial begin
    wait (squeeze);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("linear_scan_register_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    interval_t iv;
    int sent;
    int left;
    int cursor;
    int span;
    for (int c = 0; c < 2; c++)
      for (int k = 0; k < POOL_SIZE; k++) slot_file[c][k] = '0;
    plan = '{
      // fresh function, widest interval takes the first integer slot
      '{'{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0}, 1'b1, '{OUT_FREE, 4'd1, 5'd9, 16'd0}},
      '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{OUT_FREE, 4'd0, 5'd8, 16'd0}},
      '{'{1'b0, 16'h0001, 16'h0000, 16'hFFFF, 1'b1}, 1'b1, '{OUT_FREE, 4'd1, 5'd9, 16'd0}},
      '{'{1'b0, 16'h0002, 16'h0001, 16'h000A, 1'b0}, 1'b0, UNTYPED},
      // fill the rest of the integer pool
      '{'{1'b0, 16'h0003, 16'h0002, 16'h0100, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0004, 16'h0002, 16'hFFFF, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0005, 16'h0002, 16'h0300, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0006, 16'h0002, 16'h0400, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0007, 16'h0002, 16'h0500, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0008, 16'h0002, 16'h0600, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0009, 16'h0002, 16'h0700, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h000A, 16'h0002, 16'h0800, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h000B, 16'h0002, 16'h0900, 1'b0}, 1'b0, UNTYPED},
      // equal end does not evict
      '{'{1'b0, 16'h0020, 16'h0003, 16'hFFFF, 1'b0}, 1'b1, '{OUT_SPILL, 4'd0, 5'd0, 16'd0}},
      // tie on largest end: smaller id goes first
      '{'{1'b0, 16'h0021, 16'h0004, 16'h0050, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0022, 16'h0005, 16'h0060, 1'b0}, 1'b0, UNTYPED},
      // end below start, then a start that goes backwards
      '{'{1'b0, 16'h0023, 16'h000B, 16'h0005, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0024, 16'h0006, 16'h0003, 1'b0}, 1'b0, UNTYPED},
      // same id twice
      '{'{1'b0, 16'h0001, 16'h000C, 16'h0040, 1'b1}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0001, 16'h000C, 16'h0040, 1'b1}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h8000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{OUT_FREE, 4'd0, 5'd8, 16'd0}},
      // top start expires everything
      '{'{1'b0, 16'h1234, 16'hFFFF, 16'h0000, 1'b0}, 1'b1, '{OUT_FREE, 4'd1, 5'd9, 16'd0}},
      '{'{1'b0, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, '{OUT_FREE, 4'd0, 5'd8, 16'd0}}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) offer_interval(plan[r].iv, plan[r].given, plan[r].res);

    sent = 0;
    left = 0;
    cursor = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 3) begin
        snd_idle = 58;
        rcv_idle <= 13;
      end else if (sent == 2 * RANDOM_ITEMS / 3) begin
        snd_idle = 0;
        rcv_idle <= 0;
        squeeze <= 1'b1;
      end
      if (chance(15)) begin
        iv.nf = chance(10);
        iv.id = 16'($urandom);
        iv.st = 16'($urandom);
        iv.en = 16'($urandom);
        iv.fl = 1'($urandom);
      end else begin
        // well-formed function: rising starts, mostly short intervals
        if (left == 0 || cursor > 65000) begin
          left = chance(10) ? $urandom_range(100, 250) : $urandom_range(3, 60);
          cursor = $urandom_range(0, 40000);
          iv.nf = 1'b1;
        end else begin
          iv.nf = 1'b0;
        end
        span = chance(5) ? $urandom_range(0, 65535) : $urandom_range(0, 48);
        iv.id = 16'($urandom);
        iv.st = 16'(cursor);
        iv.en = (cursor + span > 65535) ? 16'hFFFF : 16'(cursor + span);
        if (chance(4) && cursor > 0) iv.en = 16'(cursor - $urandom_range(1, cursor));
        iv.fl = 1'($urandom);
        cursor += $urandom_range(0, 3);
        left--;
      end
      offer_interval(iv, 1'b0, UNTYPED);
      sent++;
    end
    s_tvalid <= 1'b0;

    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_allocs.size() == 0)
      $display("linear_scan_register_allocator: match");
    else
      $display("linear_scan_register_allocator: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/lsra_pkg.sv
hw/rtl/lsra_ctrl.sv
hw/rtl/lsra_dp.sv
hw/rtl/linear_scan_register_allocator.sv
tb/tb.sv
